// File: sv/aigsim_pkg.sv
// ============================================================================
// aigsim_pkg
// Shared field widths and command codes of the and-inverter graph simulator.
// ============================================================================
package aigsim_pkg;

    localparam int CMD_W  = 3;
    localparam int ID_W   = 12;
    localparam int WIDX_W = 3;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [DATA_W-1:0] t_word;

    localparam t_cmd CMD_WRITE   = 3'd0;
    localparam t_cmd CMD_READ    = 3'd1;
    localparam t_cmd CMD_AND     = 3'd2;
    localparam t_cmd CMD_SINGLE  = 3'd3;
    localparam t_cmd CMD_FLIP    = 3'd4;
    localparam t_cmd CMD_COMPARE = 3'd5;

    localparam logic [CFG_W-1:0] WORDS_RESET = 4'd8;

endpackage

// File: sv/aigsim_store.sv
// ============================================================================
// aigsim_store
// Simulation word store: one write port and two read ports, each read
// registered and returning its word in the cycle after the address is presented.
// ============================================================================
module aigsim_store #(
    parameter int ADDR_W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  aigsim_pkg::t_word         i_wdata,
    input  logic                      i_re,
    input  logic [ADDR_W-1:0]         i_raddr0,
    input  logic [ADDR_W-1:0]         i_raddr1,
    output aigsim_pkg::t_word         o_rdata0,
    output aigsim_pkg::t_word         o_rdata1
);
    import aigsim_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    t_word r_mem [DEPTH];
    t_word r_rdata0;
    t_word r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// File: sv/aig_bit_parallel_simulator.sv
// ============================================================================
// aig_bit_parallel_simulator
// Bit-parallel simulator for an and-inverter graph. Each node holds two
// banks of 32-bit simulation words in one store; node commands walk the
// active words through the store, one word per cycle.
// ============================================================================
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  ----------------------------------
//  cmd      in         i_valid / o_ready        i_cmd .. i_write_data
//  result   out        o_valid / i_ready        o_read_data, o_banks_equal
//  config   in         i_cfg_we                 i_cfg_data (words in use)
//
//  An accepted beat walks n words through the store, where n is the number
//  of active words for node commands and 1 for word access; no new beat is
//  taken until it is done. The store has one write port and registered reads.
//  Reset is synchronous and active low; the store itself is not cleared.
//  A result waiting in the output register stalls only the final step of
//  the following beat.
//
module aig_bit_parallel_simulator #(
    parameter int NODES     = 4096,
    parameter int MAX_WORDS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [aigsim_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  aigsim_pkg::t_cmd                 i_cmd,
    input  logic [aigsim_pkg::ID_W-1:0]      i_node_id,
    input  logic [aigsim_pkg::ID_W-1:0]      i_fanin0_id,
    input  logic [aigsim_pkg::ID_W-1:0]      i_fanin1_id,
    input  logic                             i_fanin0_inv,
    input  logic                             i_fanin1_inv,
    input  logic                             i_dest_bank,
    input  logic                             i_src0_bank,
    input  logic                             i_src1_bank,
    input  logic [aigsim_pkg::WIDX_W-1:0]    i_word_index,
    input  aigsim_pkg::t_word                i_write_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output aigsim_pkg::t_word                o_read_data,
    output logic                             o_banks_equal
);
    import aigsim_pkg::*;

    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int WORD_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int BASE_W = 1 + NODE_W;
    localparam int ADDR_W = BASE_W + WORD_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CFG_W-1:0]  r_words;
    t_cmd              r_cmd;
    logic [BASE_W-1:0] r_a_base;
    logic [BASE_W-1:0] r_b_base;
    logic [BASE_W-1:0] r_w_base;
    logic              r_fixed;
    logic [WORD_W-1:0] r_widx;
    logic              r_inv0;
    logic              r_inv1;
    t_word             r_wdata;
    logic [CNT_W-1:0]  r_steps;
    logic [CNT_W-1:0]  r_iss;
    logic              r_pv;
    logic [WORD_W-1:0] r_pk;
    t_word             r_rd;
    logic              r_eq;
    logic              r_o_valid;
    t_word             r_o_rd;
    logic              r_o_eq;

    logic              w_accept;
    logic              w_node_ok;
    logic              w_f0_ok;
    logic              w_f1_ok;
    logic              w_widx_ok;
    logic [NODE_W-1:0] w_node;
    logic [NODE_W-1:0] w_f0;
    logic [NODE_W-1:0] w_f1;
    logic [CNT_W-1:0]  w_active;
    logic [CNT_W-1:0]  w_steps;
    logic [BASE_W-1:0] w_a_base;
    logic [BASE_W-1:0] w_b_base;
    logic [BASE_W-1:0] w_w_base;
    logic              w_issue;
    logic              w_out_free;
    logic              w_we;
    t_word             w_wdata;
    t_word             w_rd0;
    t_word             w_rd1;
    t_word             w_op0;
    t_word             w_op1;
    logic [ADDR_W-1:0] w_raddr0;
    logic [ADDR_W-1:0] w_raddr1;
    logic [ADDR_W-1:0] w_waddr;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;

    assign w_node_ok = 32'(i_node_id) < 32'(NODES);
    assign w_f0_ok   = 32'(i_fanin0_id) < 32'(NODES);
    assign w_f1_ok   = 32'(i_fanin1_id) < 32'(NODES);
    assign w_widx_ok = 32'(i_word_index) < 32'(MAX_WORDS);
    assign w_node    = NODE_W'(i_node_id);
    assign w_f0      = NODE_W'(i_fanin0_id);
    assign w_f1      = NODE_W'(i_fanin1_id);

    always_comb begin
        if (r_words == '0) begin
            w_active = CNT_W'(1);
        end else if (32'(r_words) > 32'(MAX_WORDS)) begin
            w_active = CNT_W'(MAX_WORDS);
        end else begin
            w_active = CNT_W'(r_words);
        end
    end

    always_comb begin
        w_steps  = '0;
        w_a_base = {i_dest_bank, w_node};
        w_b_base = {1'b1, w_node};
        w_w_base = {i_dest_bank, w_node};
        case (i_cmd)
            CMD_WRITE, CMD_READ: begin
                w_steps = (w_node_ok && w_widx_ok) ? CNT_W'(1) : '0;
            end
            CMD_AND: begin
                w_steps  = (w_node_ok && w_f0_ok && w_f1_ok) ? w_active : '0;
                w_a_base = {i_src0_bank, w_f0};
                w_b_base = {i_src1_bank, w_f1};
            end
            CMD_SINGLE: begin
                w_steps  = (w_node_ok && w_f0_ok) ? w_active : '0;
                w_a_base = {i_src0_bank, w_f0};
            end
            CMD_FLIP: begin
                w_steps  = w_node_ok ? w_active : '0;
                w_a_base = {1'b1, w_node};
                w_w_base = {1'b0, w_node};
            end
            CMD_COMPARE: begin
                w_steps  = w_node_ok ? w_active : '0;
                w_a_base = {1'b0, w_node};
            end
            default: begin
                w_steps = '0;
            end
        endcase
    end

    assign w_issue  = (r_state == S_RUN) && (r_iss < r_steps);
    assign w_raddr0 = {r_a_base, r_fixed ? r_widx : r_iss[WORD_W-1:0]};
    assign w_raddr1 = {r_b_base, r_fixed ? r_widx : r_iss[WORD_W-1:0]};
    assign w_waddr  = {r_w_base, r_fixed ? r_widx : r_pk};

    assign w_op0 = w_rd0 ^ {DATA_W{r_inv0}};
    assign w_op1 = w_rd1 ^ {DATA_W{r_inv1}};

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_wdata;
        case (r_cmd)
            CMD_WRITE: begin
                w_we    = r_pv;
                w_wdata = r_wdata;
            end
            CMD_AND: begin
                w_we    = r_pv;
                w_wdata = w_op0 & w_op1;
            end
            CMD_SINGLE: begin
                w_we    = r_pv;
                w_wdata = w_op0;
            end
            CMD_FLIP: begin
                w_we    = r_pv;
                w_wdata = ~w_rd0;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    aigsim_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_re     (w_issue),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_rd0),
        .o_rdata1 (w_rd1)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_iss == r_steps) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_words   <= WORDS_RESET;
            r_iss     <= '0;
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_words <= i_cfg_data;
            end
            if (w_accept) begin
                r_iss <= '0;
            end else if (w_issue) begin
                r_iss <= r_iss + CNT_W'(1);
            end
            r_pv <= w_issue;
            if (r_state == S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_a_base <= w_a_base;
            r_b_base <= w_b_base;
            r_w_base <= w_w_base;
            r_fixed  <= (i_cmd == CMD_WRITE) || (i_cmd == CMD_READ);
            r_widx   <= WORD_W'(i_word_index);
            r_inv0   <= i_fanin0_inv;
            r_inv1   <= i_fanin1_inv;
            r_wdata  <= i_write_data;
            r_steps  <= w_steps;
            r_rd     <= '0;
            r_eq     <= (i_cmd == CMD_COMPARE) && w_node_ok;
        end else if (r_pv) begin
            if (r_cmd == CMD_READ) begin
                r_rd <= w_rd0;
            end
            if (r_cmd == CMD_COMPARE && w_rd0 != w_rd1) begin
                r_eq <= 1'b0;
            end
        end
        if (w_issue) begin
            r_pk <= r_iss[WORD_W-1:0];
        end
        if (r_state == S_DONE && w_out_free) begin
            r_o_rd <= r_rd;
            r_o_eq <= r_eq;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_read_data   = r_o_rd;
    assign o_banks_equal = r_o_eq;

    a_no_pending_when_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!r_pv && !w_we))
        else $error("store access pending while a new beat can be taken");

    a_issue_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_iss <= r_steps))
        else $error("word issue counter ran past its limit");

    a_accept_starts_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RUN && r_iss == '0))
        else $error("accepted beat did not start a walk");

    a_done_delivers : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_valid && o_ready))
        else $error("finished beat did not reach the output register");

endmodule
